// ===== rtl/sei_ins_pkg.sv =====
// Shared types, constants and the SEI byte table for the SEI frame-id inserter.
package sei_ins_pkg;

  localparam int HEAD_LEN    = 5;
  localparam int SEI_LEN     = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [4:0] NAL_TYPE_MASK   = 5'h1F;
  localparam logic [7:0] NAL_SEI_HDR     = 8'h06;
  localparam logic [7:0] SEI_PT_UDU      = 8'h05;
  localparam logic [7:0] SEI_PAYLOAD_LEN = 8'h18;
  localparam logic [7:0] SEI_STOP        = 8'h80;
  localparam logic [7:0] START_ONE       = 8'h01;

  localparam logic [0:0] REG_UUID_HIGH = 1'b0;
  localparam logic [0:0] REG_UUID_LOW  = 1'b1;

  // One queued job: emit count held bytes, optionally preceded by an SEI unit
  typedef struct packed {
    logic [HEAD_LEN-1:0][7:0] bytes;
    logic [2:0]               count;
    logic                     sei;
    logic                     unit_end;
  } cmd_t;

  // Byte i of the inserted SEI unit
  function automatic logic [7:0] sei_byte(input logic [4:0] i, input logic [63:0] uuid_hi,
                                          input logic [63:0] uuid_lo,
                                          input logic [63:0] fcount);
    logic [7:0] b;
    logic [2:0] k;
    b = 8'h00;
    k = 3'd0;
    case (i) inside
      5'd0, 5'd1, 5'd2: b = 8'h00;
      5'd3:             b = START_ONE;
      5'd4:             b = NAL_SEI_HDR;
      5'd5:             b = SEI_PT_UDU;
      5'd6:             b = SEI_PAYLOAD_LEN;
      [5'd7:5'd14]: begin
        k = 3'(5'd14 - i);
        b = uuid_hi[{k, 3'b000} +: 8];
      end
      [5'd15:5'd22]: begin
        k = 3'(5'd22 - i);
        b = uuid_lo[{k, 3'b000} +: 8];
      end
      [5'd23:5'd30]: begin
        k = 3'(5'd30 - i);
        b = fcount[{k, 3'b000} +: 8];
      end
      default:          b = SEI_STOP;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/sei_ins_front.sv =====
// Front part: holds the unit head, judges it and queues emit jobs.
module sei_ins_front import sei_ins_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_unit_end,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [7:0] head [HEAD_LEN];
  logic [2:0] bytes_seen;
  logic       decided;
  logic       accept;
  logic [HEAD_LEN-1:0][7:0] comp;
  logic       is_slice;
  logic [4:0] nal_type;
  logic       last_head;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign last_head = (bytes_seen == 3'(HEAD_LEN - 1));

  // Merge the incoming byte into the held head
  always_comb begin
    for (int k = 0; k < HEAD_LEN; k++) begin
      comp[k] = (bytes_seen == 3'(k)) ? in_byte : head[k];
    end
  end

  // Find the start code and test the NAL type for a slice
  always_comb begin
    nal_type = 5'd0;
    is_slice = 1'b0;
    if (comp[0] == 8'h00 && comp[1] == 8'h00 && comp[2] == 8'h00 && comp[3] == START_ONE) begin
      nal_type = comp[4][4:0] & NAL_TYPE_MASK;
      is_slice = (nal_type >= 5'd1) && (nal_type <= 5'd5);
    end else if (comp[0] == 8'h00 && comp[1] == 8'h00 && comp[2] == START_ONE) begin
      nal_type = comp[3][4:0] & NAL_TYPE_MASK;
      is_slice = (nal_type >= 5'd1) && (nal_type <= 5'd5);
    end
  end

  // Build the job for this transaction
  always_comb begin
    q_cmd.bytes    = comp;
    q_cmd.unit_end = in_unit_end;
    q_cmd.count    = 3'd1;
    q_cmd.sei      = 1'b0;
    q_push         = 1'b0;
    if (accept) begin
      if (decided) begin
        q_push = 1'b1;
      end else if (last_head) begin
        q_push      = 1'b1;
        q_cmd.count = 3'(HEAD_LEN);
        q_cmd.sei   = is_slice;
      end else if (in_unit_end) begin
        q_push      = 1'b1;
        q_cmd.count = bytes_seen + 3'd1;
      end
    end
  end

  // Store head bytes
  always_ff @(posedge clk) begin
    if (accept && !decided) begin
      head[bytes_seen] <= in_byte;
    end
  end

  // Advance the head count and pass-through flag
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= 3'd0;
      decided    <= 1'b0;
    end else if (accept) begin
      if (decided) begin
        if (in_unit_end) decided <= 1'b0;
      end else if (last_head) begin
        bytes_seen <= 3'd0;
        decided    <= !in_unit_end;
      end else if (in_unit_end) begin
        bytes_seen <= 3'd0;
      end else begin
        bytes_seen <= bytes_seen + 3'd1;
      end
    end
  end

endmodule

// ===== rtl/sei_ins_fifo.sv =====
// Short job queue between the front and back parts.
module sei_ins_fifo import sei_ins_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic empty,
  output logic full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign empty    = (fill == '0);
  assign full     = (fill == CW'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem[rd_ptr];

  // Write the new job
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

endmodule

// ===== rtl/sei_ins_back.sv =====
// Back part: plays out queued jobs byte by byte into the output register.
module sei_ins_back import sei_ins_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] uuid_high,
  input  logic [63:0] uuid_low,
  input  cmd_t        cmd,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_unit_end,
  output logic        from_sei,
  output logic        run_end
);

  logic [5:0]  idx;
  logic [63:0] frame_count;
  logic [5:0]  last_pos;
  logic        is_last;
  logic        in_sei;
  logic        emit;
  logic [7:0]  byte_sel;

  assign last_pos = 6'(cmd.count) - 6'd1 + (cmd.sei ? 6'(SEI_LEN) : 6'd0);
  assign is_last  = (idx == last_pos);
  assign in_sei   = cmd.sei && !idx[5];
  assign emit     = !q_empty && (!out_valid || out_ready);
  assign q_pop    = emit && is_last;
  assign byte_sel = in_sei ? sei_byte(idx[4:0], uuid_high, uuid_low, frame_count)
                           : cmd.bytes[idx[2:0]];

  // Step through the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= 6'd0;
      frame_count <= 64'd0;
    end else if (emit) begin
      idx <= is_last ? 6'd0 : idx + 6'd1;
      if (in_sei && idx[4:0] == 5'(SEI_LEN - 1)) frame_count <= frame_count + 64'd1;
    end
  end

  // Hold the output transaction until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte     <= byte_sel;
      out_unit_end <= is_last && cmd.unit_end;
      from_sei     <= in_sei;
      run_end      <= is_last;
    end
  end

endmodule

// ===== rtl/h264_sei_frame_id_inserter.sv =====
// Top level of the H.264 SEI frame-id inserter.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------
//  s_axis   | in  | tvalid / tready        | tdata = in_byte, tlast = in_unit_end
//  m_axis   | out | tvalid / tready        | tdata = out_byte, tlast = out_unit_end,
//           |     |                        | tuser = from_sei, run_end
//  cfg      | in  | cfg_we (no wait)       | cfg_index, cfg_data (64 bits)
//
// In the back part a pass-through byte yields one output byte, a full head flush
// five, and a slice head with its SEI unit 37.
// Input is taken one byte per cycle while the job queue has room; it stalls
// only while the queue is full, as when the back part falls behind on long jobs.
// Reset is synchronous and clears the head count, queue, counter and output.
// A stall on m_axis holds the output register and backs up into the queue.
module h264_sei_frame_id_inserter import sei_ins_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // [0] from_sei, [1] run_end
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] uuid_high;
  logic [63:0] uuid_low;
  cmd_t        push_cmd;
  cmd_t        head_cmd;
  logic        push;
  logic        pop;
  logic        q_empty;
  logic        q_full;
  logic        from_sei;
  logic        run_end;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      uuid_high <= 64'h1234567812341234;
      uuid_low  <= 64'h1234567890123456;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UUID_HIGH: uuid_high <= cfg_data;
        REG_UUID_LOW:  uuid_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  sei_ins_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_unit_end(s_axis_tlast),
    .q_full     (q_full),
    .q_push     (push),
    .q_cmd      (push_cmd)
  );

  sei_ins_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head_cmd(head_cmd),
    .empty   (q_empty),
    .full    (q_full)
  );

  sei_ins_back u_back (
    .clk         (clk),
    .rst         (rst),
    .uuid_high   (uuid_high),
    .uuid_low    (uuid_low),
    .cmd         (head_cmd),
    .q_empty     (q_empty),
    .q_pop       (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_byte    (m_axis_tdata),
    .out_unit_end(m_axis_tlast),
    .from_sei    (from_sei),
    .run_end     (run_end)
  );

  assign m_axis_tuser = {run_end, from_sei};

endmodule

// ===== rtl/sei_ins_checker.sv =====
// Port-level checks for the SEI frame-id inserter, bound to the top level.
module sei_ins_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  // Output register is empty right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A stalled output transaction holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled output changed");

  // SEI bytes never close a unit
  a_sei_no_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast)
    else $error("SEI byte flagged as unit end");

  // SEI bytes are never the last result of an input byte
  a_sei_no_run_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
    else $error("SEI byte flagged as run end");

  // A unit end is always the last result of its input byte
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
    else $error("unit end without run end");

endmodule

bind h264_sei_frame_id_inserter sei_ins_checker u_sei_ins_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);
